### sv/pfx_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Used by pfx_alu and postfix_expression_evaluator_core.
package pfx_pkg;

   localparam int DATA_W          = 32;
   localparam int SYMBOL_W        = 8;
   localparam int STATUS_W        = 3;
   localparam int STACK_DEPTH_DEF = 16;

   // ASCII codes of the recognized characters
   localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [SYMBOL_W-1:0] CH_CARET = 8'h5E;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_DIV0  = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_POW
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_DIV,
      A_SIGN,
      A_POW,
      A_DONE
   } alu_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_RHS,
      S_RD_LHS,
      S_EXEC,
      S_ALU,
      S_FIN_RD,
      S_FIN_OUT
   } ctl_state_type;

endpackage

### sv/pfx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pfx_alu.sv
// Multi-cycle arithmetic unit: add, subtract, multiply, restoring divide,
// and power by repeated squaring. Depends on pfx_pkg.
module pfx_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  pfx_pkg::alu_ctl_type        ctl,
   input  logic [pfx_pkg::DATA_W-1:0]  lhs,
   input  logic [pfx_pkg::DATA_W-1:0]  rhs,
   output logic                        done,
   output logic [pfx_pkg::DATA_W-1:0]  result
);
   import pfx_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   alu_state_type      state_ff, state_in;
   logic [DATA_W-1:0]  res_ff, res_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  base_ff, base_in;
   logic [DATA_W-1:0]  exp_ff, exp_in;
   logic [DATA_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;

   logic [DATA_W-1:0]  prod_acc;
   logic [DATA_W-1:0]  prod_sq;
   logic [DATA_W:0]    rem_sh;
   logic [DATA_W:0]    rem_diff;

   // Low halves only: arithmetic wraps at the data width
   assign prod_acc = acc_ff * base_ff;
   assign prod_sq  = base_ff * base_ff;

   // One restoring step: acc_ff carries the quotient, base_ff the divisor
   assign rem_sh   = {rem_ff, acc_ff[DATA_W-1]};
   assign rem_diff = rem_sh - {1'b0, base_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               case (ctl.op)
                  OP_ADD:  state_in = A_DONE;
                  OP_SUB:  state_in = A_DONE;
                  OP_MUL:  state_in = A_MUL;
                  OP_DIV:  state_in = A_DIV;
                  OP_POW:  state_in = rhs[DATA_W-1] ? A_DONE : A_POW;
                  default: state_in = A_DONE;
               endcase
            end
         end
         A_MUL:   state_in = A_DONE;
         A_DIV:   state_in = (cnt_ff == CNT_W'(DATA_W - 1)) ? A_SIGN : A_DIV;
         A_SIGN:  state_in = A_DONE;
         A_POW:   state_in = (exp_ff == '0) ? A_DONE : A_POW;
         A_DONE:  state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == A_DONE);
      result = res_ff;
   end

   always_comb begin
      res_in  = res_ff;
      acc_in  = acc_ff;
      base_in = base_ff;
      exp_in  = exp_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               case (ctl.op)
                  OP_ADD: res_in = lhs + rhs;
                  OP_SUB: res_in = lhs - rhs;
                  OP_MUL: begin
                     acc_in  = lhs;
                     base_in = rhs;
                  end
                  OP_DIV: begin
                     acc_in  = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
                     base_in = rhs[DATA_W-1] ? (DATA_W'(0) - rhs) : rhs;
                     neg_in  = lhs[DATA_W-1] ^ rhs[DATA_W-1];
                     rem_in  = '0;
                     cnt_in  = '0;
                  end
                  OP_POW: begin
                     acc_in  = DATA_W'(1);
                     base_in = lhs;
                     exp_in  = rhs;
                     // Negative exponent: only bases one and minus one survive
                     if (lhs == DATA_W'(1)) begin
                        res_in = DATA_W'(1);
                     end else if (lhs == '1) begin
                        res_in = rhs[0] ? '1 : DATA_W'(1);
                     end else begin
                        res_in = '0;
                     end
                  end
                  default: res_in = '0;
               endcase
            end
         end
         A_MUL: res_in = prod_acc;
         A_DIV: begin
            if (!rem_diff[DATA_W]) begin
               rem_in = rem_diff[DATA_W-1:0];
               acc_in = {acc_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DATA_W-1:0];
               acc_in = {acc_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         A_SIGN: res_in = neg_ff ? (DATA_W'(0) - acc_ff) : acc_ff;
         A_POW: begin
            if (exp_ff == '0) begin
               res_in = acc_ff;
            end else begin
               acc_in  = exp_ff[0] ? prod_acc : acc_ff;
               base_in = prod_sq;
               exp_in  = exp_ff >> 1;
            end
         end
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      res_ff  <= res_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      exp_ff  <= exp_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == A_IDLE)
      else $error("alu start while busy");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == A_DIV && cnt_ff == CNT_W'(DATA_W - 1)) |=> state_ff == A_SIGN)
      else $error("divider did not finish after full count");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("alu done held longer than one cycle");

endmodule

### sv/postfix_expression_evaluator_core.sv
// Postfix evaluator: operand stack in a RAM, sequencer, multi-cycle ALU.
// Per word: a digit is pushed; an operator reads two operands and runs the ALU (32 divide steps).
// Expression end reads the stack top, then loads the result register.
// Reset (synchronous, active high) empties the stack and clears the error.
// Stack RAM contents are not cleared; only written entries are ever used.
module postfix_expression_evaluator_core #(
   parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pfx_pkg::SYMBOL_W-1:0]        req_symbol,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pfx_pkg::DATA_W-1:0]   rsp_value,
   output logic [pfx_pkg::STATUS_W-1:0]        rsp_status
);
   import pfx_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   ctl_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   status_type           err_ff, err_in;
   logic [SYMBOL_W-1:0]  sym_ff, sym_in;
   logic                 last_ff, last_in;
   logic [DATA_W-1:0]    rhs_ff, rhs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic                 is_digit;
   logic                 rsp_free;
   logic [ADDR_W-1:0]    addr_top;
   logic [ADDR_W-1:0]    addr_below;

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [DATA_W-1:0]    mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [DATA_W-1:0]    mem_rd_data;

   alu_ctl_type          alu_ctl;
   logic                 alu_done;
   logic [DATA_W-1:0]    alu_result;
   logic                 exec_div0;

   assign accept     = req_valid && !req_stall;
   assign is_digit   = req_symbol inside {[CH_ZERO:CH_NINE]};
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign addr_top   = ADDR_W'(count_ff - CNT_W'(1));
   assign addr_below = ADDR_W'(count_ff - CNT_W'(2));

   // Operator decode for the execute step
   always_comb begin
      alu_ctl   = '{start: 1'b0, op: OP_ADD};
      exec_div0 = 1'b0;
      if (state_ff == S_EXEC) begin
         case (sym_ff)
            CH_PLUS:  alu_ctl = '{start: 1'b1, op: OP_ADD};
            CH_MINUS: alu_ctl = '{start: 1'b1, op: OP_SUB};
            CH_STAR:  alu_ctl = '{start: 1'b1, op: OP_MUL};
            CH_CARET: alu_ctl = '{start: 1'b1, op: OP_POW};
            CH_SLASH: begin
               if (rhs_ff == '0) begin
                  exec_div0 = 1'b1;
               end else begin
                  alu_ctl = '{start: 1'b1, op: OP_DIV};
               end
            end
            default: alu_ctl = '{start: 1'b0, op: OP_ADD};
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (err_ff == ST_OK && !is_digit && count_ff >= CNT_W'(2)) begin
                  state_in = S_RD_RHS;
               end else begin
                  state_in = req_last ? S_FIN_RD : S_IDLE;
               end
            end
         end
         S_RD_RHS: state_in = S_RD_LHS;
         S_RD_LHS: state_in = S_EXEC;
         S_EXEC: begin
            if (alu_ctl.start) begin
               state_in = S_ALU;
            end else begin
               state_in = last_ff ? S_FIN_RD : S_IDLE;
            end
         end
         S_ALU: begin
            if (alu_done) begin
               state_in = last_ff ? S_FIN_RD : S_IDLE;
            end
         end
         S_FIN_RD:  state_in = S_FIN_OUT;
         S_FIN_OUT: state_in = rsp_free ? S_IDLE : S_FIN_OUT;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[ADDR_W-1:0];
      mem_wr_data = alu_result;
      mem_rd_en   = 1'b0;
      mem_rd_addr = addr_top;
      case (state_ff)
         S_IDLE: begin
            mem_wr_en   = accept && err_ff == ST_OK && is_digit &&
                          count_ff != CNT_W'(STACK_DEPTH);
            mem_wr_data = {{(DATA_W - SYMBOL_W){1'b0}}, req_symbol - CH_ZERO};
         end
         S_RD_RHS: mem_rd_en = 1'b1;
         S_RD_LHS: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = addr_below;
         end
         S_ALU: begin
            // count already dropped by two, so this lands on the left operand
            mem_wr_en = alu_done;
         end
         S_FIN_RD: mem_rd_en = 1'b1;
         default:  mem_rd_en = 1'b0;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      rhs_in        = rhs_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sym_in  = req_symbol;
               last_in = req_last;
               if (err_ff == ST_OK) begin
                  if (is_digit) begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        err_in = ST_OVER;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end else if (count_ff < CNT_W'(2)) begin
                     err_in = ST_UNDER;
                  end
               end
            end
         end
         S_RD_LHS: rhs_in = mem_rd_data;
         S_EXEC: begin
            count_in = count_ff - CNT_W'(2);
            if (exec_div0) begin
               err_in = ST_DIV0;
            end
         end
         S_ALU: begin
            if (alu_done) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         S_FIN_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff != ST_OK) begin
                  rsp_value_in  = '0;
                  rsp_status_in = err_ff;
               end else if (count_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_value_in  = mem_rd_data;
                  rsp_status_in = ST_OK;
               end
               count_in = '0;
               err_in   = ST_OK;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      rhs_ff        <= rhs_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   pfx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pfx_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .lhs    (mem_rd_data),
      .rhs    (rhs_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> count_ff < CNT_W'(STACK_DEPTH))
      else $error("stack write with no room");

   a_alu_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == S_ALU)
      else $error("alu result arrived outside the wait state");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN_OUT && rsp_free) |=>
         (rsp_valid_ff && count_ff == '0 && err_ff == ST_OK && state_ff == S_IDLE))
      else $error("expression end did not load result and clear stack");

endmodule
